FILE: sv/rrr_arm_inverse_kinematics_macros.svh
// Assertion macros for the rrr_arm_inverse_kinematics checker.
// No dependencies.
`ifndef RRR_ARM_INVERSE_KINEMATICS_MACROS_SVH
`define RRR_ARM_INVERSE_KINEMATICS_MACROS_SVH

// implication checked in the same cycle
`define RIK_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rik: assertion failed");

// implication checked in the next cycle
`define RIK_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rik: assertion failed");

`endif

FILE: sv/rik_pkg.sv
// Shared types, constants and helper functions for the arm inverse kinematics block.
// No dependencies.
`default_nettype none

package rik_pkg;

  localparam int REG_W      = 22;
  localparam int CFG_ADDR_W = 4;
  localparam int INT_FRAC   = 24;

  // reachable targets keep dist2 below (2*2^22)^2
  localparam int REACH_W = 2 * (REG_W + 1);
  localparam int HALF_W  = REACH_W / 2;
  localparam int NK_W    = REACH_W + 2;
  localparam int LEG_W   = HALF_W + 2;
  localparam int ROOT_W  = REACH_W;
  localparam int PROD_W  = 2 * REACH_W;
  localparam int REM_W   = ROOT_W + 4;

  localparam int NORM_W       = 58;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 28;
  localparam int CX_W         = 62;
  localparam int ANG_W        = 34;
  localparam int ATAN_LAT     = NORM_STEPS + CORDIC_STEPS + 2;

  localparam int BASE_W     = 17;
  localparam int SHOULDER_W = 18;
  localparam int ELBOW_W    = 16;
  localparam int SUM_W      = 36;
  localparam int OUT_DATA_W = 56;

  localparam logic signed [ANG_W-1:0] DEG90  = 34'sd1509949440;
  localparam logic signed [ANG_W-1:0] DEG180 = 34'sd3019898880;

  typedef enum logic [1:0] {
    REG_BASE_HEIGHT = 2'd0,
    REG_UPPER_LINK  = 2'd1,
    REG_FORE_LINK   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                    oor;
    logic signed [LEG_W-1:0] x;
    logic signed [LEG_W-1:0] y;
    logic signed [LEG_W-1:0] rise;
    logic signed [NK_W-1:0]  ncos;
    logic signed [NK_W-1:0]  kcos;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [PROD_W-1:0] rad;
  } sq_t;

  // atan(2^-i) in 2^-24 degree
  function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      0:  v = 34'sd754974720;
      1:  v = 34'sd445687602;
      2:  v = 34'sd235489088;
      3:  v = 34'sd119537938;
      4:  v = 34'sd60000934;
      5:  v = 34'sd30029717;
      6:  v = 34'sd15018523;
      7:  v = 34'sd7509720;
      8:  v = 34'sd3754917;
      9:  v = 34'sd1877466;
      10: v = 34'sd938734;
      11: v = 34'sd469367;
      12: v = 34'sd234684;
      13: v = 34'sd117342;
      14: v = 34'sd58671;
      15: v = 34'sd29335;
      16: v = 34'sd14668;
      17: v = 34'sd7334;
      18: v = 34'sd3667;
      19: v = 34'sd1833;
      20: v = 34'sd917;
      21: v = 34'sd458;
      22: v = 34'sd229;
      23: v = 34'sd115;
      24: v = 34'sd57;
      25: v = 34'sd29;
      26: v = 34'sd14;
      27: v = 34'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // one digit of a restoring square root, two radicand bits per step
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t              o;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    sh    = {s.rem[REM_W-3:0], s.rad[PROD_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    o.rad = s.rad << 2;
    if (sh >= trial) begin
      o.rem  = sh - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = sh;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rik_atan2.sv
// Pipelined atan2: magnitude, normalizing shift, 28 CORDIC vectoring steps, quadrant fixup.
// Depends on rik_pkg. The output angle is registered; the pipeline advances when en is high.
`default_nettype none

module rik_atan2 import rik_pkg::*; #(
  parameter int IN_W = 48
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [IN_W-1:0]  y_in,
  input  logic signed [IN_W-1:0]  x_in,
  output logic signed [ANG_W-1:0] angle
);

  localparam int FLAG_D = NORM_STEPS + CORDIC_STEPS + 1;

  // flags: {zero, xneg, yneg}
  logic [2:0]              flg_r [FLAG_D];
  logic [NORM_W-1:0]       nx_r  [NORM_STEPS+1];
  logic [NORM_W-1:0]       ny_r  [NORM_STEPS+1];
  logic signed [CX_W-1:0]  cx_r  [CORDIC_STEPS];
  logic signed [CX_W-1:0]  cy_r  [CORDIC_STEPS];
  logic signed [ANG_W-1:0] ang_r [CORDIC_STEPS];
  logic signed [ANG_W-1:0] angle_r;

  logic [IN_W-1:0] ax, ay;
  assign ax = x_in[IN_W-1] ? IN_W'(-x_in) : IN_W'(x_in);
  assign ay = y_in[IN_W-1] ? IN_W'(-y_in) : IN_W'(y_in);

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r[0]  <= NORM_W'(ax);
      ny_r[0]  <= NORM_W'(ay);
      flg_r[0] <= {(ax | ay) == '0, x_in[IN_W-1], y_in[IN_W-1]};
    end
  end

  for (genvar k = 1; k < FLAG_D; k++) begin : g_flag
    always_ff @(posedge clk) begin
      if (en) flg_r[k] <= flg_r[k-1];
    end
  end

  for (genvar k = 1; k <= NORM_STEPS; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - k);
    logic [NORM_W-1:0] both;
    logic              top_clear;
    assign both      = nx_r[k-1] | ny_r[k-1];
    assign top_clear = both[NORM_W-1 -: SH] == '0;
    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[k] <= top_clear ? nx_r[k-1] << SH : nx_r[k-1];
        ny_r[k] <= top_clear ? ny_r[k-1] << SH : ny_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [ANG_W-1:0] STEP_ANG = atan_tab(i);
    logic signed [CX_W-1:0]  cx_in, cy_in, dx, dy;
    logic signed [ANG_W-1:0] ang_in;
    if (i == 0) begin : g_first
      assign cx_in  = $signed(CX_W'(nx_r[NORM_STEPS]));
      assign cy_in  = $signed(CX_W'(ny_r[NORM_STEPS]));
      assign ang_in = '0;
    end else begin : g_next
      assign cx_in  = cx_r[i-1];
      assign cy_in  = cy_r[i-1];
      assign ang_in = ang_r[i-1];
    end
    assign dx = cy_in >>> i;
    assign dy = cx_in >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy_in > 0) begin
          cx_r[i]  <= cx_in + dx;
          cy_r[i]  <= cy_in - dy;
          ang_r[i] <= ang_in + STEP_ANG;
        end else begin
          cx_r[i]  <= cx_in - dx;
          cy_r[i]  <= cy_in + dy;
          ang_r[i] <= ang_in - STEP_ANG;
        end
      end
    end
  end

  logic signed [ANG_W-1:0] clamp, fixed_ang;
  logic [2:0]              flg_last;
  assign flg_last = flg_r[FLAG_D-1];

  always_comb begin
    priority if (ang_r[CORDIC_STEPS-1] < 0) clamp = '0;
    else if (ang_r[CORDIC_STEPS-1] > DEG90) clamp = DEG90;
    else clamp = ang_r[CORDIC_STEPS-1];
    fixed_ang = flg_last[1] ? DEG180 - clamp : clamp;
    if (flg_last[0]) fixed_ang = -fixed_ang;
    if (flg_last[2]) fixed_ang = '0;
  end

  always_ff @(posedge clk) begin
    if (en) angle_r <= fixed_ang;
  end

  assign angle = angle_r;

endmodule

`default_nettype wire

FILE: sv/rrr_arm_inverse_kinematics.sv
// Inverse kinematics for a base/shoulder/elbow arm, elbow-up solution; uses rik_pkg, rik_atan2.
// One target per cycle while the output is not stalled; the pipeline runs through unpack,
// squares, sums, reach tests and the split 46x46 product, 46 square root digits, the atan2
// units and one output register. The whole pipeline holds while the output register is full
// and not taken. Link lengths are written over the APB port at 0x0, 0x4, 0x8 (base height,
// upper link, fore link); the user must write them only while no transaction is in flight,
// as the block does not enforce it. out_tuser flags unreachable targets, with all angles then zero.
`default_nettype none

module rrr_arm_inverse_kinematics import rik_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 8,
  localparam int InDataW        = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [InDataW-1:0]    in_tdata,   // target_x, target_y, target_z, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // base_angle, shoulder_angle, elbow_angle, pad
  output logic                  out_tuser   // out_of_reach
);

  localparam int CW     = COORD_WIDTH;
  localparam int RISE_W = ((CW > REG_W) ? CW : REG_W) + 2;
  localparam int MR_W   = RISE_W - 1;
  localparam int H_W    = 2 * CW + 1;
  localparam int D_W    = 2 * MR_W + 2;
  localparam int RSH    = INT_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] RHalf = SUM_W'(1) << (RSH - 1);

  // configuration
  logic [REG_W-1:0] base_height_r, upper_len_r, fore_len_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r <= '0;
      upper_len_r   <= '0;
      fore_len_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_paddr[3:2]))
        REG_BASE_HEIGHT: base_height_r <= cfg_pwdata[REG_W-1:0];
        REG_UPPER_LINK:  upper_len_r   <= cfg_pwdata[REG_W-1:0];
        REG_FORE_LINK:   fore_len_r    <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_paddr[3:2]))
      REG_BASE_HEIGHT: cfg_prdata = 32'(base_height_r);
      REG_UPPER_LINK:  cfg_prdata = 32'(upper_len_r);
      REG_FORE_LINK:   cfg_prdata = 32'(fore_len_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // link-derived constants
  logic [2*REG_W-1:0]   la2_r, lb2_r;
  logic [REACH_W-1:0]   rmax_r, rmin_r;
  logic                 lzero_r;
  logic [REG_W:0]       lsum;
  logic [REG_W-1:0]     lgap;

  assign lsum = (REG_W+1)'(upper_len_r) + (REG_W+1)'(fore_len_r);
  assign lgap = (upper_len_r > fore_len_r) ? upper_len_r - fore_len_r
                                           : fore_len_r - upper_len_r;

  always_ff @(posedge clk) begin
    la2_r   <= upper_len_r * upper_len_r;
    lb2_r   <= fore_len_r * fore_len_r;
    rmax_r  <= lsum * lsum;
    rmin_r  <= REACH_W'(lgap * lgap);
    lzero_r <= (upper_len_r == '0) || (fore_len_r == '0);
  end

  logic adv;
  logic out_tvalid_r;
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // s1: unpack, rise = z - L1
  logic                     v1_r;
  logic signed [CW-1:0]     x1_r, y1_r;
  logic signed [RISE_W-1:0] rise1_r;
  logic signed [CW-1:0]     in_x, in_y, in_z;

  assign in_x = $signed(in_tdata[CW-1:0]);
  assign in_y = $signed(in_tdata[2*CW-1:CW]);
  assign in_z = $signed(in_tdata[3*CW-1:2*CW]);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= in_x;
      y1_r    <= in_y;
      rise1_r <= RISE_W'(in_z) - $signed(RISE_W'(base_height_r));
    end
  end

  // s2: squares
  logic                 v2_r;
  logic [2*CW-1:0]      x2_r, y2_r;
  logic [2*MR_W-1:0]    r2_r;
  logic signed [LEG_W-1:0] x2c_r, y2c_r, rise2c_r;
  logic [CW-1:0]        mx, my;
  logic [MR_W-1:0]      mr;

  assign mx = x1_r[CW-1] ? CW'(-x1_r) : CW'(x1_r);
  assign my = y1_r[CW-1] ? CW'(-y1_r) : CW'(y1_r);
  assign mr = rise1_r[RISE_W-1] ? MR_W'(-rise1_r) : MR_W'(rise1_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r     <= mx * mx;
      y2_r     <= my * my;
      r2_r     <= mr * mr;
      x2c_r    <= LEG_W'(x1_r);
      y2c_r    <= LEG_W'(y1_r);
      rise2c_r <= LEG_W'(rise1_r);
    end
  end

  // s3: sums
  logic                    v3_r;
  logic [H_W-1:0]          horiz3_r;
  logic [D_W-1:0]          dist3_r;
  logic signed [LEG_W-1:0] x3_r, y3_r, rise3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      horiz3_r <= H_W'(x2_r) + H_W'(y2_r);
      dist3_r  <= D_W'(x2_r) + D_W'(y2_r) + D_W'(r2_r);
      x3_r     <= x2c_r;
      y3_r     <= y2c_r;
      rise3_r  <= rise2c_r;
    end
  end

  // s4: reach test, law of cosines terms
  logic               v4_r;
  logic [REACH_W-1:0] p4_r, q4_r, hz4_r;
  side_t              side4_r;
  logic [D_W-1:0]     pdiff, qdiff;
  logic [NK_W-1:0]    dist_nk;

  assign pdiff   = D_W'(rmax_r) - dist3_r;
  assign qdiff   = dist3_r - D_W'(rmin_r);
  assign dist_nk = NK_W'(dist3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r         <= pdiff[REACH_W-1:0];
      q4_r         <= qdiff[REACH_W-1:0];
      hz4_r        <= REACH_W'(horiz3_r);
      side4_r.oor  <= lzero_r || (dist3_r > D_W'(rmax_r)) || (dist3_r < D_W'(rmin_r));
      side4_r.x    <= x3_r;
      side4_r.y    <= y3_r;
      side4_r.rise <= rise3_r;
      side4_r.ncos <= $signed(dist_nk - NK_W'(la2_r) - NK_W'(lb2_r));
      side4_r.kcos <= $signed(dist_nk + NK_W'(la2_r) - NK_W'(lb2_r));
    end
  end

  // s5: partial products of P*Q
  logic               v5_r;
  logic [REACH_W-1:0] pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r, hz5_r;
  side_t              side5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_hh_r <= p4_r[REACH_W-1:HALF_W] * q4_r[REACH_W-1:HALF_W];
      pp_hl_r <= p4_r[REACH_W-1:HALF_W] * q4_r[HALF_W-1:0];
      pp_lh_r <= p4_r[HALF_W-1:0] * q4_r[REACH_W-1:HALF_W];
      pp_ll_r <= p4_r[HALF_W-1:0] * q4_r[HALF_W-1:0];
      hz5_r   <= hz4_r;
      side5_r <= side4_r;
    end
  end

  // s6: full product
  logic               v6_r;
  logic [PROD_W-1:0]  pq6_r;
  logic [REACH_W-1:0] hz6_r;
  side_t              side6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pq6_r   <= (PROD_W'(pp_hh_r) << REACH_W)
               + ((PROD_W'(pp_hl_r) + PROD_W'(pp_lh_r)) << HALF_W)
               + PROD_W'(pp_ll_r);
      hz6_r   <= hz5_r;
      side6_r <= side5_r;
    end
  end

  // square roots: sqrt(P*Q) and sqrt(horiz2 * 2^14)
  sq_t               sq_r  [ROOT_W];
  sq_t               rh_r  [ROOT_W];
  side_t             sqs_r [ROOT_W];
  logic [ROOT_W-1:0] sqv_r;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    sq_t   sq_in, rh_in;
    side_t sd_in;
    if (j == 0) begin : g_first
      assign sq_in = '{rem: '0, root: '0, rad: pq6_r};
      assign rh_in = '{rem: '0, root: '0, rad: PROD_W'(hz6_r) << 14};
      assign sd_in = side6_r;
    end else begin : g_next
      assign sq_in = sq_r[j-1];
      assign rh_in = rh_r[j-1];
      assign sd_in = sqs_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j]  <= sqrt_step(sq_in);
        rh_r[j]  <= sqrt_step(rh_in);
        sqs_r[j] <= sd_in;
      end
    end
  end

  // atan2 units
  side_t                  sd_end;
  logic signed [NK_W-1:0] sine, rho, rise_s, x_s, y_s;
  logic signed [ANG_W-1:0] elbow_ang, beta_ang, alpha_ang, base_ang;

  assign sd_end = sqs_r[ROOT_W-1];
  assign sine   = $signed(NK_W'(sq_r[ROOT_W-1].root));
  assign rho    = $signed(NK_W'(rh_r[ROOT_W-1].root));
  assign rise_s = NK_W'(sd_end.rise) <<< 7;
  assign x_s    = NK_W'(sd_end.x);
  assign y_s    = NK_W'(sd_end.y);

  rik_atan2 #(.IN_W(NK_W)) u_elbow (
    .clk(clk), .en(adv), .y_in(sine), .x_in(sd_end.ncos), .angle(elbow_ang)
  );
  rik_atan2 #(.IN_W(NK_W)) u_beta (
    .clk(clk), .en(adv), .y_in(sine), .x_in(sd_end.kcos), .angle(beta_ang)
  );
  rik_atan2 #(.IN_W(NK_W)) u_alpha (
    .clk(clk), .en(adv), .y_in(rise_s), .x_in(rho), .angle(alpha_ang)
  );
  rik_atan2 #(.IN_W(NK_W)) u_base (
    .clk(clk), .en(adv), .y_in(y_s), .x_in(x_s), .angle(base_ang)
  );

  logic [ATAN_LAT-1:0] av_r, aoor_r;

  always_ff @(posedge clk) begin
    if (adv) aoor_r <= {aoor_r[ATAN_LAT-2:0], sd_end.oor};
  end

  // valid line through every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      sqv_r <= '0;
      av_r  <= '0;
    end else if (adv) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      sqv_r <= {sqv_r[ROOT_W-2:0], v6_r};
      av_r  <= {av_r[ATAN_LAT-2:0], sqv_r[ROOT_W-1]};
    end
  end

  // rounding and output register
  logic signed [SUM_W-1:0] base_rs, shoulder_rs, elbow_rs;
  logic [BASE_W-1:0]       base_nxt;
  logic [SHOULDER_W-1:0]   shoulder_nxt;
  logic [ELBOW_W-1:0]      elbow_nxt;
  logic                    oor_nxt;

  assign base_rs     = (SUM_W'(base_ang) + RHalf) >>> RSH;
  assign elbow_rs    = (SUM_W'(elbow_ang) + RHalf) >>> RSH;
  assign shoulder_rs = (SUM_W'(alpha_ang) - SUM_W'(beta_ang) - SUM_W'(DEG90) + RHalf) >>> RSH;

  assign oor_nxt      = aoor_r[ATAN_LAT-1];
  assign base_nxt     = oor_nxt ? '0 : base_rs[BASE_W-1:0];
  assign shoulder_nxt = oor_nxt ? '0 : shoulder_rs[SHOULDER_W-1:0];
  assign elbow_nxt    = oor_nxt ? '0 : elbow_rs[ELBOW_W-1:0];

  logic [BASE_W-1:0]     base_r;
  logic [SHOULDER_W-1:0] shoulder_r;
  logic [ELBOW_W-1:0]    elbow_r;
  logic                  oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (adv) out_tvalid_r <= av_r[ATAN_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base_r     <= base_nxt;
      shoulder_r <= shoulder_nxt;
      elbow_r    <= elbow_nxt;
      oor_r      <= oor_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_DATA_W - BASE_W - SHOULDER_W - ELBOW_W)'(0),
                       elbow_r, shoulder_r, base_r};
  assign out_tuser  = oor_r;

endmodule

`default_nettype wire

FILE: sv/rik_checker.sv
// Port-level checker for rrr_arm_inverse_kinematics, attached by bind.
// Depends on rrr_arm_inverse_kinematics_macros.svh and rik_pkg.
`default_nettype none

`include "rrr_arm_inverse_kinematics_macros.svh"

module rik_checker import rik_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // stalled result transaction holds
  `RIK_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // unreachable targets carry zero angles
  `RIK_ASSERT_IMP(a_oor_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)

  // input side only stalls when the output register is full and held
  `RIK_ASSERT_IMP(a_ready_link, clk, rst_n, 1'b1, in_tready == (!out_tvalid || out_tready))

endmodule

bind rrr_arm_inverse_kinematics rik_checker u_rik_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
